// ----- design/gns_pkg.sv -----
// shared types and constants for the grid normal stencil
`default_nettype none

package gns_pkg;

	localparam int MAX_COLUMNS_DEF = 256;

	localparam int POS_W = 24;
	localparam int DIF_W = 25;
	localparam int NRM_W = 50;
	localparam int ROW_W = 16;
	localparam int COL_W = 8;
	localparam int GC_W  = 9;
	localparam int CFG_W = 16;

	localparam logic [GC_W-1:0]  GRID_COLUMNS_RESET = 9'd64;
	localparam logic [ROW_W-1:0] GRID_ROWS_RESET    = 16'd64;
	localparam logic [ROW_W-1:0] ROW_ONE            = 16'd1;
	localparam logic [ROW_W-1:0] ROW_TWO            = 16'd2;

	localparam logic signed [NRM_W-1:0] ONE_Q16 = 50'sd65536;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_GRID_COLUMNS = 1'b0,
		REG_GRID_ROWS    = 1'b1
	} reg_index_t;

	// queue between front and back
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = 2;
	localparam int OPQ_LW    = 3;
	localparam logic [OPQ_LW:0] OPQ_FULL_AT = 4'd4;

	// result queue
	localparam int RQ_DEPTH = 16;
	localparam int RQ_AW    = 4;
	localparam int RQ_LW    = 5;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} vertex_t;

	typedef struct packed {
		vertex_t          cur;
		vertex_t          up;
		vertex_t          right;
		vertex_t          left;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit_int;
		logic             int_border;
		logic             emit_own;
	} op_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic                    last;
	} result_t;

endpackage

`default_nettype wire

// ----- design/gns_front.sv -----
// front: raster counters, classification and the two line stores
`default_nettype none

module gns_front #(
	parameter int MAX_COLUMNS = gns_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [gns_pkg::GC_W-1:0]      grid_columns,
	input  wire logic [gns_pkg::ROW_W-1:0]     grid_rows,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [gns_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [gns_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [gns_pkg::POS_W-1:0] pos_z,
	input  wire logic [gns_pkg::OPQ_LW-1:0]    op_level,
	output logic                               op_valid,
	output gns_pkg::op_t                       op
);
	import gns_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam logic [31:0] MAXC32 = MAX_COLUMNS;
	localparam logic [CW:0] COLS_MAX = MAXC32[CW:0];
	localparam logic [CW:0] COLS_ONE = 1;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [31:0]      gc32;
	logic [CW:0]      cols_eff;
	logic [CW:0]      cols_m1;
	logic [ROW_W-1:0] rows_eff;
	logic [ROW_W-1:0] rows_m1;
	logic [CW-1:0]    col;
	logic [CW-1:0]    col_nx;
	logic [ROW_W-1:0] row;
	logic             col_last;
	logic             row_last;
	logic [OPQ_LW:0]  occ;
	logic             accept;
	vertex_t          cur;

	vertex_t prev_mem [MAX_COLUMNS];
	vertex_t older_mem [MAX_COLUMNS];

	logic             valid_s1;
	vertex_t          cur_s1;
	vertex_t          prev_a_s1;
	vertex_t          right_s1;
	vertex_t          up_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;
	logic             emit_int_s1;
	logic             int_border_s1;
	logic             emit_own_s1;
	vertex_t          left_q;
	logic [31:0]      col32_s1;

	always_comb begin
		gc32 = 32'(grid_columns);
		if (grid_columns == '0) begin
			cols_eff = COLS_ONE;
		end else if (gc32 > MAXC32) begin
			cols_eff = COLS_MAX;
		end else begin
			cols_eff = gc32[CW:0];
		end
		cols_m1  = cols_eff - COLS_ONE;
		rows_eff = (grid_rows == '0) ? ROW_ONE : grid_rows;
		rows_m1  = rows_eff - ROW_ONE;

		// counters past a new size are held at the last position
		col = ({1'b0, col_q} >= cols_eff) ? cols_m1[CW-1:0] : col_q;
		row = (row_q >= rows_eff) ? rows_m1 : row_q;

		col_nx   = col + 1'b1;
		col_last = ({1'b0, col} == cols_m1);
		row_last = (row == rows_m1);

		occ    = {1'b0, op_level} + {{OPQ_LW{1'b0}}, valid_s1};
		full   = (occ >= OPQ_FULL_AT);
		accept = push && !full;

		cur.x = pos_x;
		cur.y = pos_y;
		cur.z = pos_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row + ROW_ONE;
				end else begin
					col_q <= col_nx;
					row_q <= row;
				end
			end
		end
	end

	// row above the current one: read here and at the next column, then overwrite
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_a_s1     <= prev_mem[col];
			right_s1      <= prev_mem[col_nx];
			prev_mem[col] <= cur;
		end
	end

	// two rows above: takes over the old entry in the cycle after the read
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			older_mem[col_s1] <= prev_a_s1;
		end
		if (accept) begin
			up_s1 <= older_mem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1        <= cur;
			row_s1        <= row;
			col_s1        <= col;
			emit_int_s1   <= (row >= ROW_TWO);
			int_border_s1 <= (col == '0) || col_last;
			emit_own_s1   <= (row == '0) || row_last;
		end
		if (valid_s1) begin
			left_q <= prev_a_s1;
		end
	end

	always_comb begin
		col32_s1      = 32'(col_s1);
		op_valid      = valid_s1;
		op.cur        = cur_s1;
		op.up         = up_s1;
		op.right      = right_s1;
		op.left       = left_q;
		op.row        = row_s1;
		op.col        = col32_s1[COL_W-1:0];
		op.emit_int   = emit_int_s1;
		op.int_border = int_border_s1;
		op.emit_own   = emit_own_s1;
	end

endmodule

`default_nettype wire

// ----- design/gns_op_queue.sv -----
// short queue of classified vertices between front and back
`default_nettype none

module gns_op_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire gns_pkg::op_t               wr_op,
	output logic [gns_pkg::OPQ_LW-1:0]      level,
	output logic                            rd_valid,
	output gns_pkg::op_t                    rd_op,
	input  wire logic                       rd_en
);
	import gns_pkg::*;

	op_t               mem [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wr_q;
	logic [OPQ_AW-1:0] rd_q;
	logic [OPQ_LW-1:0] cnt_q;
	logic              rd_fire;

	assign rd_valid = (cnt_q != '0);
	assign rd_fire  = rd_en && rd_valid;
	assign level    = cnt_q;
	assign rd_op    = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OPQ_LW'(wr_en) - OPQ_LW'(rd_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_q] <= wr_op;
		end
	end

endmodule

`default_nettype wire

// ----- design/gns_back.sv -----
// back: cross product pipeline and result queue
`default_nettype none

module gns_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_avail,
	input  wire gns_pkg::op_t  op,
	output logic               op_take,
	input  wire logic          pop,
	output logic               empty,
	output gns_pkg::result_t   result
);
	import gns_pkg::*;

	logic                    valid_s1;
	logic signed [DIF_W-1:0] ax_s1, ay_s1, az_s1;
	logic signed [DIF_W-1:0] bx_s1, by_s1, bz_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [COL_W-1:0]        col_s1;
	logic                    emit_int_s1, int_border_s1, emit_own_s1;

	logic                    valid_s2;
	logic signed [NRM_W-1:0] aybz_s2, azby_s2, azbx_s2, axbz_s2, axby_s2, aybx_s2;
	logic [ROW_W-1:0]        row_s2;
	logic [COL_W-1:0]        col_s2;
	logic                    emit_int_s2, int_border_s2, emit_own_s2;

	result_t           mem [RQ_DEPTH];
	logic [RQ_AW-1:0]  wr_q;
	logic [RQ_AW-1:0]  rd_q;
	logic [RQ_LW-1:0]  cnt_q;

	logic [RQ_LW-1:0]  need;
	logic [RQ_LW-1:0]  room;
	logic [1:0]        n_head, n_s1, n_s2;
	logic              wr_int, wr_own;
	logic              pop_fire;
	result_t           int_res;
	result_t           own_res;
	logic [RQ_AW-1:0]  own_addr;

	// results still to land in the queue reserve their slots before an op is taken
	always_comb begin
		n_head   = {1'b0, op.emit_int} + {1'b0, op.emit_own};
		n_s1     = valid_s1 ? ({1'b0, emit_int_s1} + {1'b0, emit_own_s1}) : 2'd0;
		n_s2     = valid_s2 ? ({1'b0, emit_int_s2} + {1'b0, emit_own_s2}) : 2'd0;
		need     = RQ_LW'(n_head) + RQ_LW'(n_s1) + RQ_LW'(n_s2);
		room     = RQ_LW'(RQ_DEPTH) - cnt_q;
		op_take  = op_avail && (need <= room);
		empty    = (cnt_q == '0);
		pop_fire = pop && !empty;
		result   = mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= op_take;
			valid_s2 <= valid_s1;
		end
	end

	// differences: down minus up, right minus left
	always_ff @(posedge clk) begin
		if (op_take) begin
			ax_s1 <= $signed({op.cur.x[POS_W-1], op.cur.x}) - $signed({op.up.x[POS_W-1], op.up.x});
			ay_s1 <= $signed({op.cur.y[POS_W-1], op.cur.y}) - $signed({op.up.y[POS_W-1], op.up.y});
			az_s1 <= $signed({op.cur.z[POS_W-1], op.cur.z}) - $signed({op.up.z[POS_W-1], op.up.z});
			bx_s1 <= $signed({op.right.x[POS_W-1], op.right.x})
				- $signed({op.left.x[POS_W-1], op.left.x});
			by_s1 <= $signed({op.right.y[POS_W-1], op.right.y})
				- $signed({op.left.y[POS_W-1], op.left.y});
			bz_s1 <= $signed({op.right.z[POS_W-1], op.right.z})
				- $signed({op.left.z[POS_W-1], op.left.z});
			row_s1        <= op.row;
			col_s1        <= op.col;
			emit_int_s1   <= op.emit_int;
			int_border_s1 <= op.int_border;
			emit_own_s1   <= op.emit_own;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			aybz_s2       <= ay_s1 * bz_s1;
			azby_s2       <= az_s1 * by_s1;
			azbx_s2       <= az_s1 * bx_s1;
			axbz_s2       <= ax_s1 * bz_s1;
			axby_s2       <= ax_s1 * by_s1;
			aybx_s2       <= ay_s1 * bx_s1;
			row_s2        <= row_s1;
			col_s2        <= col_s1;
			emit_int_s2   <= emit_int_s1;
			int_border_s2 <= int_border_s1;
			emit_own_s2   <= emit_own_s1;
		end
	end

	always_comb begin
		wr_int = valid_s2 && emit_int_s2;
		wr_own = valid_s2 && emit_own_s2;

		if (int_border_s2) begin
			int_res.nx = '0;
			int_res.ny = ONE_Q16;
			int_res.nz = '0;
		end else begin
			int_res.nx = aybz_s2 - azby_s2;
			int_res.ny = azbx_s2 - axbz_s2;
			int_res.nz = axby_s2 - aybx_s2;
		end
		// the interior normal belongs to the row above
		int_res.row  = row_s2 - ROW_ONE;
		int_res.col  = col_s2;
		int_res.last = !emit_own_s2;

		own_res.nx   = '0;
		own_res.ny   = ONE_Q16;
		own_res.nz   = '0;
		own_res.row  = row_s2;
		own_res.col  = col_s2;
		own_res.last = 1'b1;

		own_addr = wr_q + {{(RQ_AW-1){1'b0}}, wr_int};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RQ_AW'(wr_int) + RQ_AW'(wr_own);
			if (pop_fire) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + RQ_LW'(wr_int) + RQ_LW'(wr_own) - RQ_LW'(pop_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_int) begin
			mem[wr_q] <= int_res;
		end
		if (wr_own) begin
			mem[own_addr] <= own_res;
		end
	end

endmodule

`default_nettype wire

// ----- design/grid_normal_stencil_top.sv -----
// Grid normal stencil. Vertices of a grid arrive in raster order, one per cycle at
// most, and each interior vertex gets the unnormalized normal (down - up) x
// (right - left) once the vertex below it arrives; border vertices get (0, 65536, 0).
// The front accepts one vertex per cycle while the four-entry op queue has room;
// the back computes the cross product in two register stages and fills a 16-entry
// result queue, taking an op only when the queue has slots for every result in
// flight. The result side drains one result per cycle while pop is held, so in
// the last row, where each vertex gives two results, the result side sets the
// vertex rate. The line stores need no initialization; write grid_columns and
// grid_rows only while no transaction is in flight.
`default_nettype none

module grid_normal_stencil_top #(
	parameter int MAX_COLUMNS = gns_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic signed [gns_pkg::POS_W-1:0]  pos_x,
	input  wire logic signed [gns_pkg::POS_W-1:0]  pos_y,
	input  wire logic signed [gns_pkg::POS_W-1:0]  pos_z,
	input  wire logic                              pop,
	output logic                                   empty,
	output logic signed [gns_pkg::NRM_W-1:0]       normal_x,
	output logic signed [gns_pkg::NRM_W-1:0]       normal_y,
	output logic signed [gns_pkg::NRM_W-1:0]       normal_z,
	output logic [gns_pkg::ROW_W-1:0]              out_row,
	output logic [gns_pkg::COL_W-1:0]              out_col,
	output logic                                   run_last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [0:0]                        cfg_index,
	input  wire logic [gns_pkg::CFG_W-1:0]         cfg_data
);
	import gns_pkg::*;

	logic [GC_W-1:0]   grid_columns_q;
	logic [ROW_W-1:0]  grid_rows_q;
	logic              cfg_fire;

	logic              op_valid;
	op_t               front_op;
	logic [OPQ_LW-1:0] op_level;
	logic              opq_valid;
	op_t               opq_op;
	logic              op_take;
	result_t           result;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_RESET;
			grid_rows_q    <= GRID_ROWS_RESET;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_GRID_COLUMNS: begin
					grid_columns_q <= cfg_data[GC_W-1:0];
				end
				REG_GRID_ROWS: begin
					grid_rows_q <= cfg_data[ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	gns_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid_columns (grid_columns_q),
		.grid_rows    (grid_rows_q),
		.push         (push),
		.full         (full),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.op_level     (op_level),
		.op_valid     (op_valid),
		.op           (front_op)
	);

	gns_op_queue u_op_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (op_valid),
		.wr_op    (front_op),
		.level    (op_level),
		.rd_valid (opq_valid),
		.rd_op    (opq_op),
		.rd_en    (op_take)
	);

	gns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_avail (opq_valid),
		.op       (opq_op),
		.op_take  (op_take),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	assign normal_x = result.nx;
	assign normal_y = result.ny;
	assign normal_z = result.nz;
	assign out_row  = result.row;
	assign out_col  = result.col;
	assign run_last = result.last;

endmodule

`default_nettype wire

// ----- design/gns_checker.sv -----
// port-level checks on the result side of the grid normal stencil
`default_nettype none

module gns_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop,
	input  wire logic                              empty,
	input  wire logic signed [gns_pkg::NRM_W-1:0]  normal_x,
	input  wire logic signed [gns_pkg::NRM_W-1:0]  normal_y,
	input  wire logic signed [gns_pkg::NRM_W-1:0]  normal_z,
	input  wire logic [gns_pkg::ROW_W-1:0]         out_row,
	input  wire logic [gns_pkg::COL_W-1:0]         out_col,
	input  wire logic                              run_last
);
	import gns_pkg::*;

	// a waiting result keeps its row, column and normal_y until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_row) && $stable(out_col)
			&& $stable(normal_y))
	else $error("waiting result changed before pop");

	// in the last row the interior normal is followed at once by the vertex's own one
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !run_last |=> !empty && run_last
			&& out_col == $past(out_col) && out_row == $past(out_row) + ROW_ONE)
	else $error("second result of a transaction missing or misplaced");

	// the first row is border only
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_row == '0 |-> normal_x == '0 && normal_y == ONE_Q16
			&& normal_z == '0)
	else $error("first row result is not a border normal");

endmodule

bind grid_normal_stencil_top gns_checker u_gns_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pop      (pop),
	.empty    (empty),
	.normal_x (normal_x),
	.normal_y (normal_y),
	.normal_z (normal_z),
	.out_row  (out_row),
	.out_col  (out_col),
	.run_last (run_last)
);

`default_nettype wire

// ----- tb/sv/grid_normal_stencil_top_tb.sv -----
// testbench for the grid normal stencil: predicted normals checked against the result queue
`timescale 1ns / 1ps

module grid_normal_stencil_top_tb;
	import gns_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PAD     = 16;
	localparam int RANDOM_ITEMS = 80;
	localparam int MAX_REPORTS  = 40;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic [POS_W-1:0] POS_MIN = 24'h800000;
	localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;

	class normal_scoreboard;
		vertex_t          older_row [MAX_COLUMNS_DEF];
		vertex_t          previous_row [MAX_COLUMNS_DEF];
		vertex_t          previous_vertex;
		int               row_count;
		int               column_count;
		logic [GC_W-1:0]  grid_columns;
		logic [ROW_W-1:0] grid_rows;
		result_t          pending_normals [$];
		int               errors;
		int               compared;
		int               interior;
		int               vertices;
		int               reg_writes;

		function new();
			for (int i = 0; i < MAX_COLUMNS_DEF; i++) begin
				older_row[i] = '0;
				previous_row[i] = '0;
			end
			previous_vertex = '0;
			row_count = 0;
			column_count = 0;
			grid_columns = GRID_COLUMNS_RESET;
			grid_rows = GRID_ROWS_RESET;
			errors = 0;
			compared = 0;
			interior = 0;
			vertices = 0;
			reg_writes = 0;
		endfunction

		function int eff_columns();
			int c;
			c = int'(grid_columns);
			if (c < 1) c = 1;
			if (c > MAX_COLUMNS_DEF) c = MAX_COLUMNS_DEF;
			return c;
		endfunction

		function int eff_rows();
			return (grid_rows == 0) ? 1 : int'(grid_rows);
		endfunction

		// counters that a size change left past the end are taken as the last position
		function void current_position(output int row, output int col);
			row = (row_count >= eff_rows()) ? eff_rows() - 1 : row_count;
			col = (column_count >= eff_columns()) ? eff_columns() - 1 : column_count;
		endfunction

		function int left_in_frame();
			int row, col;
			current_position(row, col);
			return (eff_rows() - 1 - row) * eff_columns() + (eff_columns() - col);
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
			reg_writes++;
			if (idx == REG_GRID_COLUMNS)
				grid_columns = data[GC_W-1:0];
			else
				grid_rows = data[ROW_W-1:0];
		endfunction

		function longint sx(logic [POS_W-1:0] v);
			return {{(64-POS_W){v[POS_W-1]}}, v};
		endfunction

		function result_t make_normal(longint nx, longint ny, longint nz, int row, int col);
			result_t r;
			r.nx = nx[NRM_W-1:0];
			r.ny = ny[NRM_W-1:0];
			r.nz = nz[NRM_W-1:0];
			r.row = row[ROW_W-1:0];
			r.col = col[COL_W-1:0];
			r.last = 1'b0;
			return r;
		endfunction

		function void note_vertex(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
				logic [POS_W-1:0] z);
			vertex_t cur;
			result_t outs [2];
			int n, cols, rows, row, col;
			longint ax, ay, az, bx, by, bz;
			cols = eff_columns();
			rows = eff_rows();
			current_position(row, col);
			cur.x = x;
			cur.y = y;
			cur.z = z;
			n = 0;
			vertices++;
			// the vertex above this one is now complete
			if (row >= 2) begin
				if (col == 0 || col == cols - 1) begin
					outs[n] = make_normal(0, longint'(ONE_Q16), 0, row - 1, col);
				end else begin
					ax = sx(cur.x) - sx(older_row[col].x);
					ay = sx(cur.y) - sx(older_row[col].y);
					az = sx(cur.z) - sx(older_row[col].z);
					bx = sx(previous_row[col + 1].x) - sx(previous_vertex.x);
					by = sx(previous_row[col + 1].y) - sx(previous_vertex.y);
					bz = sx(previous_row[col + 1].z) - sx(previous_vertex.z);
					outs[n] = make_normal(ay * bz - az * by, az * bx - ax * bz,
						ax * by - ay * bx, row - 1, col);
					interior++;
				end
				n++;
			end
			if (row == 0 || row == rows - 1) begin
				outs[n] = make_normal(0, longint'(ONE_Q16), 0, row, col);
				n++;
			end
			if (n > 0) outs[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++) pending_normals.push_back(outs[i]);
			previous_vertex = previous_row[col];
			older_row[col] = previous_row[col];
			previous_row[col] = cur;
			if (col + 1 >= cols) begin
				column_count = 0;
				row_count = (row + 1 >= rows) ? 0 : row + 1;
			end else begin
				column_count = col + 1;
				row_count = row;
			end
		endfunction

		function void report(string field, result_t want, logic signed [63:0] exp_v,
				logic signed [63:0] act_v);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s of normal (%0d,%0d) expected %0d actual %0d",
					$time, field, want.row, want.col, exp_v, act_v);
		endfunction

		function void check_normal(logic signed [NRM_W-1:0] nx, logic signed [NRM_W-1:0] ny,
				logic signed [NRM_W-1:0] nz, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
				logic last);
			result_t want;
			if (pending_normals.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: normal (%0d,%0d) popped with nothing expected",
						$time, row, col);
				return;
			end
			want = pending_normals.pop_front();
			compared++;
			if (nx !== want.nx) report("normal_x", want, 64'(want.nx), 64'(nx));
			if (ny !== want.ny) report("normal_y", want, 64'(want.ny), 64'(ny));
			if (nz !== want.nz) report("normal_z", want, 64'(want.nz), 64'(nz));
			if (row !== want.row) report("out_row", want, 64'(want.row), 64'(row));
			if (col !== want.col) report("out_col", want, 64'(want.col), 64'(col));
			if (last !== want.last) report("run_last", want, 64'(want.last), 64'(last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	logic pop = 1'b0;
	logic empty;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic run_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	normal_scoreboard sb;

	int burst_left = 0;
	int sent_count = 0;
	bit no_gaps = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_tick = 0;
	int rx_mode = 0;

	grid_normal_stencil_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.pop       (pop),
		.empty     (empty),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_last  (run_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// every transaction on the three channels is seen here
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(reg_index_t'(cfg_index), cfg_data);
			if (push && !full) sb.note_vertex(pos_x, pos_y, pos_z);
			if (pop && !empty)
				sb.check_normal(normal_x, normal_y, normal_z, out_row, out_col, run_last);
		end
	end

	// receiver: random stall patterns, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			pop <= 1'b0;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			rx_tick <= rx_tick + 1;
			if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ((rx_tick % 5) < 3);
			endcase
		end
	end

	function automatic vertex_t vtx(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic [POS_W-1:0] z);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		return v;
	endfunction

	function automatic logic [POS_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic vertex_t make_vertex();
		int style;
		style = $urandom_range(0, 19);
		if (style < 5)
			return vtx(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
		if (style < 7)
			return vtx(pick_extreme(), pick_extreme(), pick_extreme());
		// heightfield-like: small offsets around the origin
		return vtx(POS_W'($urandom_range(0, 10000) - 5000),
			POS_W'($urandom_range(0, 10000) - 5000),
			POS_W'($urandom_range(0, 10000) - 5000));
	endfunction

	task automatic wait_idle();
		push <= 1'b0;
		@(negedge clk);
		while (sb.pending_normals.size() != 0) @(negedge clk);
		// a vertex of row one leaves no result behind, so give the pipeline time to drain
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [CFG_W-1:0] data, bit more = 1'b0);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(logic [CFG_W-1:0] cols_data, logic [CFG_W-1:0] rows_data);
		wait_idle();
		write_register(REG_GRID_COLUMNS, cols_data, 1'b1);
		write_register(REG_GRID_ROWS, rows_data);
	endtask

	task automatic send_vertex(vertex_t v);
		int gap;
		if (burst_left == 0) begin
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		push <= 1'b1;
		pos_x <= v.x;
		pos_y <= v.y;
		pos_z <= v.z;
		do @(posedge clk); while (full);
		sent_count++;
	endtask

	// sends up to the end of the current frame, optionally resizing it part way through
	task automatic send_frame(bit allow_change);
		int left, split;
		push <= 1'b0;
		@(negedge clk);
		left = sb.left_in_frame();
		@(posedge clk);
		split = (allow_change && left > 1 && $urandom_range(0, 4) == 0) ?
			$urandom_range(1, left - 1) : -1;
		for (int i = 0; i < left; i++) begin
			if (i == split) begin
				wait_idle();
				// only shrinking the row length keeps the line stores fully written
				if ($urandom_range(0, 1))
					write_register(REG_GRID_COLUMNS,
						CFG_W'($urandom_range(1, sb.eff_columns())));
				else
					write_register(REG_GRID_ROWS, CFG_W'($urandom_range(0, sb.eff_rows() + 4)));
				@(negedge clk);
				left = i + sb.left_in_frame();
				@(posedge clk);
			end
			send_vertex(make_vertex());
		end
	endtask

	initial begin
		int start;
		logic [CFG_W-1:0] cols_data, rows_data;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest grid with an interior vertex, driven to the largest cross product
		set_grid(3, 3);
		send_vertex(vtx(POS_MAX, 0, POS_MIN));
		send_vertex(vtx(POS_MIN, POS_MIN, POS_MIN));
		send_vertex(vtx(0, POS_MAX, '1));
		send_vertex(vtx(POS_MIN, POS_MAX, POS_MIN));
		send_vertex(vtx(1, '1, 1));
		send_vertex(vtx(POS_MAX, POS_MIN, POS_MAX));
		send_vertex(vtx('1, POS_MIN, 0));
		send_vertex(vtx(POS_MAX, POS_MAX, POS_MAX));
		send_vertex(vtx(POS_MIN, 0, POS_MAX));
		// single row
		set_grid(5, 1);
		send_vertex(vtx(POS_MAX, POS_MAX, POS_MAX));
		send_vertex(vtx(POS_MIN, POS_MIN, POS_MIN));
		send_frame(1'b0);
		// zero columns act as one column
		set_grid(0, 3);
		send_frame(1'b0);
		// two by two: all border
		set_grid(2, 2);
		send_frame(1'b0);
		// zero rows act as one row
		set_grid(4, 0);
		send_frame(1'b0);

		// row length beyond the store clamps to its full depth; upper data bits are dropped
		set_grid(16'hFFFF, 1);
		send_frame(1'b0);

		// shrink the row length while the column counter is past the new end
		set_grid(8, 5);
		repeat (22) send_vertex(make_vertex());
		wait_idle();
		write_register(REG_GRID_COLUMNS, 4);
		send_frame(1'b0);

		// tallest frame, cut short by a row count below the current row
		set_grid(16'hFE03, 16'hFFFF);
		repeat (15) send_vertex(make_vertex());
		wait_idle();
		write_register(REG_GRID_ROWS, 3);
		send_frame(1'b0);

		// receiver holds off while the sender keeps pushing
		set_grid(10, 6);
		hold_req <= hold_req + 1;
		no_gaps = 1'b1;
		send_frame(1'b0);
		no_gaps = 1'b0;

		start = sent_count;
		while (sent_count - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: cols_data = CFG_W'($urandom_range(0, 2));
				1: cols_data = CFG_W'($urandom_range(13, 32));
				default: cols_data = CFG_W'($urandom_range(3, 12));
			endcase
			if ($urandom_range(0, 3) == 0) cols_data[CFG_W-1:GC_W] = (CFG_W-GC_W)'($urandom);
			case ($urandom_range(0, 9))
				0: rows_data = CFG_W'($urandom_range(0, 2));
				1: rows_data = CFG_W'($urandom_range(9, 14));
				default: rows_data = CFG_W'($urandom_range(3, 8));
			endcase
			set_grid(cols_data, rows_data);
			send_frame(1'b1);
		end

		wait_idle();
		$display("covered %0d vertices and %0d register writes: extreme, clamped, border-only",
			sb.vertices, sb.reg_writes);
		$display("and mid-frame resized grids; %0d normals compared (%0d interior), %0d errors",
			sb.compared, sb.interior, sb.errors);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d normals still expected", sb.pending_normals.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
